/* rtl/set_assoc_writeback_lru_cache_top_assert.svh */
// Assertion macros for the cache block.
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH

// Check that a property holds on every clock outside reset.
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define SALC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/salc_pkg.sv */
package salc_pkg;

  localparam int unsigned AddrBits   = 12;
  localparam int unsigned LineBytes  = 16;
  localparam int unsigned TotalLines = 16;
  localparam int unsigned Ways       = 4;
  localparam int unsigned OffBits    = 4;
  localparam int unsigned SetBits    = 2;
  localparam int unsigned TagBits    = AddrBits - OffBits - SetBits;
  localparam int unsigned WayBits    = 2;
  localparam int unsigned SlotBits   = SetBits + WayBits;
  localparam int unsigned LineW      = LineBytes * 8;
  localparam int unsigned RowBits    = AddrBits - OffBits;
  localparam int unsigned MemRows    = 1 << RowBits;
  localparam int unsigned StampW     = 32;

  typedef struct packed {
    logic                mode;
    logic [AddrBits-1:0] address;
    logic [7:0]          write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]          read_data;
    logic                hit;
    logic                evicted;
    logic                evicted_dirty;
    logic [AddrBits-1:0] evicted_line_address;
  } rsp_t;

  // Request split into its address fields.
  typedef struct packed {
    logic               mode;
    logic [TagBits-1:0] tag;
    logic [SetBits-1:0] set_idx;
    logic [OffBits-1:0] offset;
    logic [7:0]         wdata;
  } dec_t;

  typedef struct packed {
    logic valid;
    dec_t req;
  } queue_head_t;

endpackage

/* rtl/salc_ram.sv */
module salc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one entry, register the read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/salc_front.sv */
module salc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  salc_pkg::req_t        req_i,
  output logic                  full,
  input  logic                  deq_i,
  output salc_pkg::queue_head_t head_o
);
  import salc_pkg::*;

  dec_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  dec_t       dec;

  // Split the address into tag, set and offset.
  always_comb begin
    dec.mode    = req_i.mode;
    dec.offset  = req_i.address[OffBits-1:0];
    dec.set_idx = req_i.address[OffBits +: SetBits];
    dec.tag     = req_i.address[AddrBits-1 -: TagBits];
    dec.wdata   = req_i.write_data;
  end

  assign full    = (count_q == 2'd2);
  assign do_push = push && !full;
  assign do_pop  = deq_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.req   = entry_q[rd_ptr_q];

  // Store entries.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/salc_back.sv */
module salc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  salc_pkg::queue_head_t head_i,
  output logic                  deq_o,
  output salc_pkg::rsp_t        rsp_o,
  output logic                  empty,
  input  logic                  pop
);
  import salc_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e                state_q;
  logic [TotalLines-1:0] valid_q, dirty_q;
  logic [TagBits-1:0]    tag_q   [TotalLines];
  logic [StampW-1:0]     stamp_q [TotalLines];
  logic [MemRows-1:0]    mvalid_q;
  logic [StampW-1:0]     clock_q;
  logic                  rsp_valid_q;
  rsp_t                  rsp_q;

  dec_t                  cur_q;
  logic [SlotBits-1:0]   slot_q;
  logic                  hit_q, ev_q, evd_q;
  logic [TagBits-1:0]    vtag_q;

  // Lookup signals.
  logic                  start;
  logic                  found, have_free;
  logic [WayBits-1:0]    hit_way, free_way, lru_way, sel_way;
  logic [SlotBits-1:0]   slot_d, s_idx;
  logic [LineW-1:0]      line_rd, mem_rd, fill, merged;
  logic [RowBits-1:0]    fill_row, ev_row;
  logic [6:0]            bit_idx;
  logic                  mem_we;

  assign start = (state_q == ST_IDLE) && head_i.valid && !rsp_valid_q;
  assign deq_o = start;

  // Search the set for a hit, a free way and the oldest way.
  always_comb begin
    found    = 1'b0;
    have_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    s_idx    = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      s_idx = {head_i.req.set_idx, WayBits'(w)};
      if (valid_q[s_idx] && tag_q[s_idx] == head_i.req.tag) begin
        found   = 1'b1;
        hit_way = WayBits'(w);
      end
      if (!valid_q[s_idx]) begin
        have_free = 1'b1;
        free_way  = WayBits'(w);
      end
    end
    for (int w = 1; w < Ways; w++) begin
      if (stamp_q[{head_i.req.set_idx, WayBits'(w)}]
          < stamp_q[{head_i.req.set_idx, lru_way}]) begin
        lru_way = WayBits'(w);
      end
    end
    priority if (found) begin
      sel_way = hit_way;
    end else if (have_free) begin
      sel_way = free_way;
    end else begin
      sel_way = lru_way;
    end
    slot_d = {head_i.req.set_idx, sel_way};
  end

  assign fill_row = {head_i.req.tag, head_i.req.set_idx};
  assign ev_row   = {vtag_q, cur_q.set_idx};
  assign mem_we   = (state_q == ST_EXEC) && evd_q;

  salc_ram #(.Width(LineW), .Depth(TotalLines)) u_lines (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_EXEC),
    .waddr_i (slot_q),
    .wdata_i (merged),
    .raddr_i (slot_d),
    .rdata_o (line_rd)
  );

  salc_ram #(.Width(LineW), .Depth(MemRows)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (ev_row),
    .wdata_i (line_rd),
    .raddr_i (fill_row),
    .rdata_o (mem_rd)
  );

  // Pick the line contents and merge a written byte.
  assign bit_idx = {cur_q.offset, 3'b000};
  always_comb begin
    if (hit_q) begin
      fill = line_rd;
    end else if (mvalid_q[{cur_q.tag, cur_q.set_idx}]) begin
      fill = mem_rd;
    end else begin
      fill = '0;
    end
    merged = fill;
    if (cur_q.mode) begin
      merged[bit_idx +: 8] = cur_q.wdata;
    end
  end

  // Hold the request being worked on; write its tag and stamp in the execute step.
  always_ff @(posedge clk_i) begin
    if (start) begin
      cur_q  <= head_i.req;
      slot_q <= slot_d;
      hit_q  <= found;
      ev_q   <= !found && !have_free;
      evd_q  <= !found && !have_free && dirty_q[slot_d];
      vtag_q <= tag_q[slot_d];
    end
    if (state_q == ST_EXEC) begin
      tag_q[slot_q]   <= cur_q.tag;
      stamp_q[slot_q] <= clock_q;
    end
  end

  // Sequence the lookup and execute steps, update status, hold the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      dirty_q     <= '0;
      mvalid_q    <= '0;
      clock_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (pop && rsp_valid_q) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            clock_q <= clock_q + StampW'(1);
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          valid_q[slot_q] <= 1'b1;
          dirty_q[slot_q] <= cur_q.mode || (hit_q && dirty_q[slot_q]);
          if (evd_q) begin
            mvalid_q[ev_row] <= 1'b1;
          end
          rsp_q.read_data            <= merged[bit_idx +: 8];
          rsp_q.hit                  <= hit_q;
          rsp_q.evicted              <= ev_q;
          rsp_q.evicted_dirty        <= evd_q;
          rsp_q.evicted_line_address <= ev_q ? {vtag_q, cur_q.set_idx, OffBits'(0)} : '0;
          rsp_valid_q                <= 1'b1;
          state_q                    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o = rsp_q;
  assign empty = !rsp_valid_q;

endmodule

/* rtl/set_assoc_writeback_lru_cache_top.sv */
// Channel   | Handshake        | Payload
// ----------+------------------+---------------------------
// request   | push / full      | req_i (mode, address, data)
// result    | empty / pop      | rsp_o (byte, hit, eviction)
//
// In the back end each request goes through tag lookup and line/memory reads,
// then merge, write-back and result capture.
// Reset clears valid, dirty and per-row memory valid bits at once; tags, stamps
// and line contents are only read once written, so no clearing pass is needed.
// A two-entry request queue keeps accepting while a result waits; the back end
// starts a request only once the result is popped.
module set_assoc_writeback_lru_cache_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  input  salc_pkg::req_t req_i,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output salc_pkg::rsp_t rsp_o
);
  import salc_pkg::*;

  `include "set_assoc_writeback_lru_cache_top_assert.svh"

  queue_head_t head;
  logic        deq;

  salc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .req_i  (req_i),
    .full   (full),
    .deq_i  (deq),
    .head_o (head)
  );

  salc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .deq_o  (deq),
    .rsp_o  (rsp_o),
    .empty  (empty),
    .pop    (pop)
  );

  // Check result consistency and that a request starts only with room for its result.
  `SALC_NEVER(a_dirty_evict, !empty && rsp_o.evicted_dirty && !rsp_o.evicted, "bad dirty flag")
  `SALC_NEVER(a_hit_no_evict, !empty && rsp_o.hit && rsp_o.evicted, "eviction on a hit")
  `SALC_NEVER(a_evict_aligned, !empty && |rsp_o.evicted_line_address[OffBits-1:0], "unaligned")
  `SALC_ASSERT(a_deq_has_room, deq |-> (head.valid && empty), "request started without room")

endmodule
